/* rtl/core/hspd_pkg.sv */
// Package for the humidity sensor pulse decoder core.
// Holds the shared types, codes and constants; no dependencies.
`default_nettype none

package hspd_pkg;

  // Frame geometry
  localparam int unsigned HSPD_BYTE_W      = 8;
  localparam int unsigned HSPD_FRAME_W     = 40;
  localparam int unsigned HSPD_IDX_W       = 6;
  localparam int unsigned HSPD_QUEUE_DEPTH = 2;

  localparam logic [HSPD_IDX_W-1:0] HSPD_LAST_BIT   = 6'd39;
  localparam logic [HSPD_IDX_W-1:0] HSPD_NO_BAD_BIT = 6'd40;

  // Configuration reset values
  localparam logic [HSPD_BYTE_W-1:0] HSPD_MIN_WIDTH_RST = 8'd24;
  localparam logic [HSPD_BYTE_W-1:0] HSPD_MAX_WIDTH_RST = 8'd77;
  localparam logic [HSPD_BYTE_W-1:0] HSPD_ONE_THR_RST   = 8'd49;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_MIN_WIDTH     = 2'd0,
    CFG_MAX_WIDTH     = 2'd1,
    CFG_ONE_THRESHOLD = 2'd2,
    CFG_SENSOR_KIND   = 2'd3
  } hspd_cfg_idx_e;

  // Input command codes
  typedef enum logic {
    CMD_PULSE       = 1'b0,
    CMD_NO_RESPONSE = 1'b1
  } hspd_cmd_e;

  // Sensor data formats
  typedef enum logic {
    KIND_BYTE_TENTHS = 1'b0,
    KIND_WORD_TENTHS = 1'b1
  } hspd_kind_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TIMEOUT   = 2'd1,
    ST_BAD_WIDTH = 2'd2,
    ST_CHECKSUM  = 2'd3
  } hspd_status_e;

  // Input beat
  typedef struct packed {
    hspd_cmd_e                cmd;
    logic [HSPD_BYTE_W-1:0]   pulse_width;
  } hspd_in_t;

  // Result beat
  typedef struct packed {
    hspd_status_e             status;
    logic [15:0]              humidity_tenths;
    logic [15:0]              temperature_tenths;
    logic [HSPD_IDX_W-1:0]    bad_bit_index;
  } hspd_out_t;

  // Configuration seen by the front end
  typedef struct packed {
    logic [HSPD_BYTE_W-1:0]   min_width;
    logic [HSPD_BYTE_W-1:0]   max_width;
    logic [HSPD_BYTE_W-1:0]   one_threshold;
  } hspd_cfg_t;

  // Classified pulse held in the queue
  typedef struct packed {
    logic                     no_resp;
    logic                     bad;
    logic                     bit_val;
  } hspd_entry_t;

  // Completed frame handed to the report stage
  typedef struct packed {
    logic                     no_resp;
    logic [HSPD_IDX_W-1:0]    first_bad;
    logic [HSPD_FRAME_W-1:0]  bits;
  } hspd_frame_t;

endpackage

`default_nettype wire

/* rtl/core/hspd_chan_if.sv */
// Valid/ready channel interface used for the pulse input and result output.
// Payload type is a parameter; no package dependency.
`default_nettype none

interface hspd_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* rtl/core/humidity_sensor_pulse_decoder_core.sv */
// Humidity sensor pulse decoder: takes one measured high-pulse width (or a
// no-response event) per beat and returns one result per 40-pulse frame or per
// no-response event. A pulse beat is accepted every cycle while the queue has
// room; the result of a frame passes from the queue through the frame record
// and then the result register to the output, and a new frame can start while
// the last result is still on its way unless the output stalls. The output
// register lets input beats keep flowing while a result waits to be taken.
// Configuration writes take effect on the next cycle; the user must make them
// only while the block is idle, as the block does not enforce this. Depends on
// hspd_pkg, hspd_chan_if, hspd_front, hspd_fifo, hspd_frame and hspd_report.
`default_nettype none

module humidity_sensor_pulse_decoder_core
  import hspd_pkg::*;
#(
  parameter int unsigned QueueDepth = HSPD_QUEUE_DEPTH
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [1:0]             cfg_idx_i,
  input  wire logic [HSPD_BYTE_W-1:0] cfg_wdata_i,
  hspd_chan_if.sink                   pulse_i,
  hspd_chan_if.source                 result_o
);

  hspd_cfg_t    cfg_q;
  hspd_kind_e   kind_q;
  logic         q_full, q_push, q_valid, q_pop;
  hspd_entry_t  q_wdata, q_head;
  logic         rec_valid, rec_ready;
  hspd_frame_t  rec;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_width     <= HSPD_MIN_WIDTH_RST;
      cfg_q.max_width     <= HSPD_MAX_WIDTH_RST;
      cfg_q.one_threshold <= HSPD_ONE_THR_RST;
      kind_q              <= KIND_BYTE_TENTHS;
    end else if (cfg_we_i) begin
      unique case (hspd_cfg_idx_e'(cfg_idx_i))
        CFG_MIN_WIDTH:     cfg_q.min_width     <= cfg_wdata_i;
        CFG_MAX_WIDTH:     cfg_q.max_width     <= cfg_wdata_i;
        CFG_ONE_THRESHOLD: cfg_q.one_threshold <= cfg_wdata_i;
        CFG_SENSOR_KIND:   kind_q              <= hspd_kind_e'(cfg_wdata_i[0]);
        default: ;
      endcase
    end
  end

  hspd_front u_front (
    .pulse_i  (pulse_i),
    .cfg_i    (cfg_q),
    .q_full_i (q_full),
    .push_o   (q_push),
    .entry_o  (q_wdata)
  );

  hspd_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rdata_o (q_head)
  );

  hspd_frame u_frame (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (q_valid),
    .head_i       (q_head),
    .pop_o        (q_pop),
    .rec_valid_o  (rec_valid),
    .rec_o        (rec),
    .rec_ready_i  (rec_ready)
  );

  hspd_report u_report (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .sensor_kind_i (kind_q),
    .rec_valid_i   (rec_valid),
    .rec_i         (rec),
    .rec_ready_o   (rec_ready),
    .result_o      (result_o)
  );

endmodule

`default_nettype wire

/* rtl/core/hspd_front.sv */
// Front end: takes pulse beats and classifies them against the width window.
// Depends on hspd_pkg and hspd_chan_if.
`default_nettype none

module hspd_front
  import hspd_pkg::*;
(
  hspd_chan_if.sink          pulse_i,
  input  hspd_cfg_t          cfg_i,
  input  logic               q_full_i,
  output logic               push_o,
  output hspd_entry_t        entry_o
);

  logic [HSPD_BYTE_W-1:0] width;
  logic                   out_of_window;

  assign width = pulse_i.payload.pulse_width;

  // Window check; an inverted window flags every pulse
  assign out_of_window = (width < cfg_i.min_width) || (width > cfg_i.max_width);

  // Bad pulses shift in a zero
  always_comb begin
    entry_o.no_resp = (pulse_i.payload.cmd == CMD_NO_RESPONSE);
    entry_o.bad     = out_of_window;
    entry_o.bit_val = !out_of_window && (width > cfg_i.one_threshold);
  end

  assign pulse_i.ready = !q_full_i;
  assign push_o        = pulse_i.valid && !q_full_i;

endmodule

`default_nettype wire

/* rtl/core/hspd_fifo.sv */
// Short queue of classified pulses between front end and frame assembler.
// Depends on hspd_pkg for the entry type.
`default_nettype none

module hspd_fifo
  import hspd_pkg::*;
#(
  parameter int unsigned Depth = HSPD_QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  hspd_entry_t wdata_i,
  output logic        full_o,
  input  logic        pop_i,
  output logic        valid_o,
  output hspd_entry_t rdata_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  hspd_entry_t     mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == FullCnt);
  assign valid_o = (count_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt)
    else $error("queue fill count beyond depth");
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("empty queue with pointers apart");
`endif

endmodule

`default_nettype wire

/* rtl/core/hspd_frame.sv */
// Frame assembler: counts pulses, shifts bits in and keeps the first bad index.
// Depends on hspd_pkg.
`default_nettype none

module hspd_frame
  import hspd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        head_valid_i,
  input  hspd_entry_t head_i,
  output logic        pop_o,
  output logic        rec_valid_o,
  output hspd_frame_t rec_o,
  input  logic        rec_ready_i
);

  logic [HSPD_IDX_W-1:0]   bit_count_q, bit_count_d;
  logic [HSPD_IDX_W-1:0]   first_bad_q, first_bad_d;
  logic [HSPD_FRAME_W-1:0] bits_q, bits_d;
  logic [HSPD_IDX_W-1:0]   upd_bad;
  logic [HSPD_FRAME_W-1:0] upd_bits;
  logic                    frame_end;

  // Next frame contents with the head beat folded in
  always_comb begin
    upd_bad = first_bad_q;
    if (head_i.bad && (first_bad_q == HSPD_NO_BAD_BIT)) begin
      upd_bad = bit_count_q;
    end
    upd_bits = {bits_q[HSPD_FRAME_W-2:0], head_i.bit_val};
  end

  // A no-response beat or the last pulse closes the frame
  assign frame_end   = head_valid_i && (head_i.no_resp || (bit_count_q == HSPD_LAST_BIT));
  assign rec_valid_o = frame_end;
  assign pop_o       = head_valid_i && (!frame_end || rec_ready_i);

  always_comb begin
    rec_o.no_resp   = head_i.no_resp;
    rec_o.first_bad = upd_bad;
    rec_o.bits      = upd_bits;
  end

  // State update
  always_comb begin
    bit_count_d = bit_count_q;
    first_bad_d = first_bad_q;
    bits_d      = bits_q;
    if (pop_o) begin
      if (frame_end) begin
        bit_count_d = '0;
        first_bad_d = HSPD_NO_BAD_BIT;
        bits_d      = '0;
      end else begin
        bit_count_d = bit_count_q + 1'b1;
        first_bad_d = upd_bad;
        bits_d      = upd_bits;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_count_q <= '0;
      first_bad_q <= HSPD_NO_BAD_BIT;
      bits_q      <= '0;
    end else begin
      bit_count_q <= bit_count_d;
      first_bad_q <= first_bad_d;
      bits_q      <= bits_d;
    end
  end

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_count_q <= HSPD_LAST_BIT)
    else $error("pulse count beyond frame length");
  a_bad_before_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (first_bad_q == HSPD_NO_BAD_BIT) || (first_bad_q < bit_count_q))
    else $error("first bad index not behind pulse count");
`endif

endmodule

`default_nettype wire

/* rtl/core/hspd_report.sv */
// Report stage: checks the frame sum and formats the result beat.
// Depends on hspd_pkg and hspd_chan_if.
`default_nettype none

module hspd_report
  import hspd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  hspd_kind_e  sensor_kind_i,
  input  logic        rec_valid_i,
  input  hspd_frame_t rec_i,
  output logic        rec_ready_o,
  hspd_chan_if.source result_o
);

  hspd_frame_t            rec_q;
  logic                   rec_vld_q;
  hspd_out_t              out_q, res_d;
  logic                   out_vld_q;
  logic                   out_free;
  logic [HSPD_BYTE_W-1:0] b0, b1, b2, b3, b4, sum;

  // Two bytes into tenths in the configured format
  function automatic logic [15:0] combine(input hspd_kind_e kind,
                                          input logic [7:0] hi,
                                          input logic [7:0] lo);
    logic [15:0] hi_w;
    hi_w = {8'd0, hi};
    if (kind == KIND_WORD_TENTHS) begin
      combine = {hi, lo};
    end else begin
      combine = (hi_w << 3) + (hi_w << 1) + {8'd0, lo};
    end
  endfunction

  assign b0  = rec_q.bits[39:32];
  assign b1  = rec_q.bits[31:24];
  assign b2  = rec_q.bits[23:16];
  assign b3  = rec_q.bits[15:8];
  assign b4  = rec_q.bits[7:0];
  assign sum = b0 + b1 + b2 + b3;

  // Result selection, first match wins
  always_comb begin
    res_d.status             = ST_OK;
    res_d.humidity_tenths    = '0;
    res_d.temperature_tenths = '0;
    res_d.bad_bit_index      = HSPD_NO_BAD_BIT;
    priority if (rec_q.no_resp) begin
      res_d.status = ST_TIMEOUT;
    end else if (rec_q.first_bad != HSPD_NO_BAD_BIT) begin
      res_d.status        = ST_BAD_WIDTH;
      res_d.bad_bit_index = rec_q.first_bad;
    end else if (sum != b4) begin
      res_d.status = ST_CHECKSUM;
    end else begin
      res_d.humidity_tenths    = combine(sensor_kind_i, b0, b1);
      res_d.temperature_tenths = combine(sensor_kind_i, b2, b3);
    end
  end

  // Two-stage handshake: frame record then result register
  assign out_free    = !out_vld_q || result_o.ready;
  assign rec_ready_o = !rec_vld_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (rec_ready_o) begin
        rec_vld_q <= rec_valid_i;
      end
      if (out_free) begin
        out_vld_q <= rec_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rec_ready_o && rec_valid_i) begin
      rec_q <= rec_i;
    end
    if (out_free && rec_vld_q) begin
      out_q <= res_d;
    end
  end

  assign result_o.valid   = out_vld_q;
  assign result_o.payload = out_q;

`ifndef ASSERT_OFF
  a_ok_no_bad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && (out_q.status == ST_OK)) |-> (out_q.bad_bit_index == HSPD_NO_BAD_BIT))
    else $error("ok result carries a bad bit index");
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && (out_q.status != ST_OK))
      |-> ((out_q.humidity_tenths == '0) && (out_q.temperature_tenths == '0)))
    else $error("failed result carries measurement data");
`endif

endmodule

`default_nettype wire
